### rtl/raae_pkg.sv
// Shared types, widths and constants for the rotation axis and angle extractor.
package raae_pkg;

    // Signed Q1.14 matrix entry or axis component.
    typedef logic signed [15:0] t_q14;

    localparam int Q_ONE = 16384;

    // Axis division: numerator |a| * 2^14 + sine, divisor floor(sqrt(s2)).
    localparam int NUM_W = 31;
    localparam int DEN_W = 17;
    localparam int QUO_W = 15;

    // Vectoring CORDIC for the arcsine.
    localparam int CORDIC_N = 15;
    localparam int CRD_W    = 26;
    localparam int ANG_W    = 16;

    // Arctangent of 2^-i in units of pi/32768.
    localparam logic signed [ANG_W-1:0] ATAN_TAB [CORDIC_N] = '{
        16'sd8192, 16'sd4836, 16'sd2555, 16'sd1297, 16'sd651, 16'sd326, 16'sd163,
        16'sd81, 16'sd41, 16'sd20, 16'sd10, 16'sd5, 16'sd3, 16'sd1, 16'sd1
    };

    // Register stages from the input item to the last stage before the output register.
    localparam int PIPE_DEPTH = 53;

endpackage

### rtl/raae_dly.sv
// Enabled delay line used to keep side data level with the arithmetic stages.
module raae_dly #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);

    logic [W-1:0] r_sr [D];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr[0] <= i_d;
            for (int k = 1; k < D; k++) begin
                r_sr[k] <= r_sr[k-1];
            end
        end
    end

    assign o_d = r_sr[D-1];

endmodule

### rtl/raae_isqrt.sv
// Pipelined integer square root, one result bit resolved per stage.
module raae_isqrt #(
    parameter int W = 34
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [W-1:0]   i_v,
    output logic [W/2-1:0] o_r
);

    localparam int N = W / 2;

    logic [N+1:0] r_rem  [N];
    logic [N-1:0] r_root [N];
    logic [W-1:0] r_val  [N];

    for (genvar k = 0; k < N; k++) begin : g_stg
        logic [N+1:0] rem_in;
        logic [N-1:0] root_in;
        logic [W-1:0] val_in;
        logic [N+3:0] remx;
        logic [N+3:0] trial;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign val_in  = i_v;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign val_in  = r_val[k-1];
        end

        // Bring down the next bit pair and try the digit one.
        assign remx  = {rem_in, val_in[W-1:W-2]};
        assign trial = {2'b00, root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (remx >= trial) begin
                    r_rem[k]  <= (N+2)'(remx - trial);
                    r_root[k] <= {root_in[N-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= remx[N+1:0];
                    r_root[k] <= {root_in[N-2:0], 1'b0};
                end
                r_val[k] <= {val_in[W-3:0], 2'b00};
            end
        end
    end

    assign o_r = r_root[N-1];

endmodule

### rtl/raae_div.sv
// Pipelined restoring divider for one axis component, one quotient bit per stage.
module raae_div
    import raae_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_q
);

    logic [NUM_W-1:0] r_rem [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_q   [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stg
        localparam int B = QUO_W - 1 - k;

        logic [NUM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] q_in;
        logic [NUM_W:0]   trial;
        logic             take;

        if (k == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign q_in   = r_q[k-1];
        end

        assign trial = (NUM_W+1)'(den_in) << B;
        assign take  = {1'b0, rem_in} >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= take ? NUM_W'({1'b0, rem_in} - trial) : rem_in;
                r_den[k] <= den_in;
                r_q[k]   <= {q_in[QUO_W-2:0], take};
            end
        end
    end

    assign o_q = r_q[QUO_W-1];

endmodule

### rtl/raae_cordic.sv
// Pipelined vectoring CORDIC giving the arcsine angle from cosine and sine.
module raae_cordic
    import raae_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [14:0] i_c,
    input  logic [14:0] i_s,
    output logic [14:0] o_z
);

    logic signed [CRD_W-1:0] r_x [CORDIC_N];
    logic signed [CRD_W-1:0] r_y [CORDIC_N];
    logic signed [ANG_W-1:0] r_z [CORDIC_N];

    // Arithmetic shift that truncates toward zero.
    function automatic logic signed [CRD_W-1:0] f_shr_tz(
        input logic signed [CRD_W-1:0] v,
        input int                      sh
    );
        logic [CRD_W-1:0] mag;
        mag = v[CRD_W-1] ? CRD_W'(-v) : CRD_W'(v);
        mag = mag >> sh;
        return v[CRD_W-1] ? $signed(-mag) : $signed(mag);
    endfunction

    for (genvar k = 0; k < CORDIC_N; k++) begin : g_stg
        logic signed [CRD_W-1:0] x_in;
        logic signed [CRD_W-1:0] y_in;
        logic signed [ANG_W-1:0] z_in;
        logic signed [CRD_W-1:0] dx;
        logic signed [CRD_W-1:0] dy;

        if (k == 0) begin : g_first
            assign x_in = $signed(CRD_W'({i_c, 8'h00}));
            assign y_in = $signed(CRD_W'({i_s, 8'h00}));
            assign z_in = '0;
        end else begin : g_next
            assign x_in = r_x[k-1];
            assign y_in = r_y[k-1];
            assign z_in = r_z[k-1];
        end

        assign dx = f_shr_tz(y_in, k);
        assign dy = f_shr_tz(x_in, k);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (y_in > 0) begin
                    r_x[k] <= x_in + dx;
                    r_y[k] <= y_in - dy;
                    r_z[k] <= z_in + ATAN_TAB[k];
                end else begin
                    r_x[k] <= x_in - dx;
                    r_y[k] <= y_in + dy;
                    r_z[k] <= z_in - ATAN_TAB[k];
                end
            end
        end
    end

    // The accumulated angle is limited to a quarter turn.
    always_comb begin
        if (r_z[CORDIC_N-1] < 0) begin
            o_z = '0;
        end else if (r_z[CORDIC_N-1] > ANG_W'(Q_ONE)) begin
            o_z = 15'(Q_ONE);
        end else begin
            o_z = r_z[CORDIC_N-1][14:0];
        end
    end

endmodule

### rtl/rotation_axis_angle_extract.sv
// Top level of the rotation axis and angle extractor.
//
// Channel      Direction  Handshake                          Content
// s_axis       in         i_s_axis_tvalid / o_s_axis_tready  one 3x3 matrix per item
// m_axis       out        o_m_axis_tvalid / i_m_axis_tready  axis, angle and flags per item
// cfg          in         i_cfg_valid / o_cfg_ready          min_sine register write
//
// One item is accepted in every cycle in which the output is free or being taken.
// The result of an item passes through 54 register stages, counting the input capture;
// the depth is set by the square root of the axis length (17 stages), the arcsine
// square root (15 stages) and the CORDIC (15 stages) lying one after another.
// The whole pipeline advances together: it freezes only while a result sits in the
// output register and is not taken, so a stall neither loses nor repeats an item.
// Reset (synchronous, active low) clears the valid bits, the output register and
// sets min_sine to 16; the data registers are not reset.
module rotation_axis_angle_extract
    import raae_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [143:0] i_s_axis_tdata,  // m00, m01, m02, m10, m11, m12, m20, m21, m22
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [63:0]  o_m_axis_tdata,  // axis_x, axis_y, axis_z, angle
    output logic [1:0]   o_m_axis_tuser,  // is_proper, degenerate
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [14:0]  i_cfg_data       // min_sine
);

    logic                  en;
    logic [14:0]           r_min_sine;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic                  r_ovld;
    logic [63:0]           r_odata;
    logic [1:0]            r_ouser;

    // Every stage moves on together unless the output holds an item that is not taken.
    assign en              = !r_ovld || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_sine <= 15'd16;
        end else if (i_cfg_valid) begin
            r_min_sine <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (en) begin
            r_vld  <= {r_vld[PIPE_DEPTH-2:0], i_s_axis_tvalid};
            r_ovld <= r_vld[PIPE_DEPTH-1];
        end
    end

    // Stage 1: capture the matrix.
    t_q14 r_m [9];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 9; i++) begin
                r_m[i] <= i_s_axis_tdata[16*i +: 16];
            end
        end
    end

    // Stage 2: doubled axis from the antisymmetric part, and the 2x2 minors' products.
    logic signed [16:0] r_a2 [3];
    logic signed [31:0] r_p2 [6];
    t_q14               r_row2 [3];
    t_q14               r_dg2 [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a2[0] <= 17'(r_m[5]) - 17'(r_m[7]);
            r_a2[1] <= 17'(r_m[6]) - 17'(r_m[2]);
            r_a2[2] <= 17'(r_m[1]) - 17'(r_m[3]);
            r_p2[0] <= r_m[4] * r_m[8];
            r_p2[1] <= r_m[5] * r_m[7];
            r_p2[2] <= r_m[3] * r_m[8];
            r_p2[3] <= r_m[5] * r_m[6];
            r_p2[4] <= r_m[3] * r_m[7];
            r_p2[5] <= r_m[4] * r_m[6];
            r_row2  <= '{r_m[0], r_m[1], r_m[2]};
            r_dg2   <= '{r_m[0], r_m[4], r_m[8]};
        end
    end

    // Stage 3: cofactors and squared axis components.
    logic signed [32:0] r_cof3 [3];
    logic [32:0]        r_asq3 [3];
    logic signed [16:0] r_a3 [3];
    t_q14               r_row3 [3];
    t_q14               r_dg3 [3];
    logic signed [33:0] asq [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            asq[i] = r_a2[i] * r_a2[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cof3[0] <= 33'(r_p2[0]) - 33'(r_p2[1]);
            r_cof3[1] <= 33'(r_p2[2]) - 33'(r_p2[3]);
            r_cof3[2] <= 33'(r_p2[4]) - 33'(r_p2[5]);
            for (int i = 0; i < 3; i++) begin
                r_asq3[i] <= asq[i][32:0];
            end
            r_a3   <= r_a2;
            r_row3 <= r_row2;
            r_dg3  <= r_dg2;
        end
    end

    // Stage 4: determinant terms and the squared length of the doubled axis.
    logic signed [48:0] r_term4 [3];
    logic [33:0]        r_s2_4;
    logic signed [16:0] r_a4 [3];
    t_q14               r_dg4 [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_term4[i] <= r_row3[i] * r_cof3[i];
            end
            r_s2_4 <= 34'(r_asq3[0]) + 34'(r_asq3[1]) + 34'(r_asq3[2]);
            r_a4   <= r_a3;
            r_dg4  <= r_dg3;
        end
    end

    // Stage 5: determinant sign.
    logic               r_prop5;
    logic signed [50:0] det;

    assign det = 51'(r_term4[0]) - 51'(r_term4[1]) + 51'(r_term4[2]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prop5 <= !det[50];
        end
    end

    // Stages 5 to 21: r = floor(sqrt(s2)), with the side data kept level.
    logic [16:0] r21;
    logic        prop21;
    logic [50:0] a21;
    logic [47:0] dg21;

    raae_isqrt #(.W(34)) u_len_sqrt (
        .i_clk (i_clk),
        .i_en  (en),
        .i_v   (r_s2_4),
        .o_r   (r21)
    );

    raae_dly #(.W(1), .D(16)) u_dly_prop21 (
        .i_clk (i_clk), .i_en (en), .i_d (r_prop5), .o_d (prop21)
    );

    raae_dly #(.W(51), .D(17)) u_dly_a21 (
        .i_clk (i_clk), .i_en (en),
        .i_d   ({r_a4[2], r_a4[1], r_a4[0]}),
        .o_d   (a21)
    );

    raae_dly #(.W(48), .D(17)) u_dly_dg21 (
        .i_clk (i_clk), .i_en (en),
        .i_d   ({r_dg4[2], r_dg4[1], r_dg4[0]}),
        .o_d   (dg21)
    );

    // Stage 22: sine, degenerate test, clamped sine and the division numerators.
    logic [15:0]        sine21;
    logic signed [16:0] a21_i [3];
    logic [15:0]        mag21 [3];
    logic [NUM_W-1:0]   r_num22 [3];
    logic [DEN_W-1:0]   r_den22;
    logic [2:0]         r_neg22;
    logic [14:0]        r_scl22;
    logic               r_deg22;
    logic               r_prop22;
    logic [47:0]        r_dg22;

    assign sine21 = r21[16:1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a21_i[i] = $signed(a21[17*i +: 17]);
            mag21[i] = a21_i[i][16] ? 16'(-a21_i[i]) : a21_i[i][15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_num22[i] <= {1'b0, mag21[i], 14'd0} + NUM_W'(sine21);
                r_neg22[i] <= a21_i[i][16];
            end
            r_den22  <= r21;
            r_scl22  <= (sine21 > 16'(Q_ONE)) ? 15'(Q_ONE) : sine21[14:0];
            r_deg22  <= (r21 == '0) || (sine21 < {1'b0, r_min_sine});
            r_prop22 <= prop21;
            r_dg22   <= dg21;
        end
    end

    // Stages 23 to 37: unit axis magnitudes.
    logic [QUO_W-1:0] q37 [3];
    logic [2:0]       neg37;
    logic [47:0]      dg38;

    for (genvar i = 0; i < 3; i++) begin : g_div
        raae_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_num22[i]),
            .i_den (r_den22),
            .o_q   (q37[i])
        );
    end

    raae_dly #(.W(3), .D(15)) u_dly_neg37 (
        .i_clk (i_clk), .i_en (en), .i_d (r_neg22), .o_d (neg37)
    );

    raae_dly #(.W(48), .D(16)) u_dly_dg38 (
        .i_clk (i_clk), .i_en (en), .i_d (r_dg22), .o_d (dg38)
    );

    // Stage 38: signed axis and squared components.
    t_q14        r_n38 [3];
    logic [29:0] r_sq38 [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_n38[i]  <= neg37[i] ? -$signed({1'b0, q37[i]}) : $signed({1'b0, q37[i]});
                r_sq38[i] <= 30'(q37[i]) * 30'(q37[i]);
            end
        end
    end

    // Stage 39: pick the first component whose square is at most a third (else the
    // smallest), and test the cosine sign on its diagonal entry.
    logic [2:0]         qual;
    logic [2:0]         flip;
    logic [1:0]         sel;
    logic [1:0]         sel_min;
    t_q14               dg38_i [3];
    logic signed [31:0] dg_sc [3];
    logic               r_flip39;
    logic [47:0]        r_n39;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dg38_i[i] = $signed(dg38[16*i +: 16]);
            dg_sc[i]  = 32'(dg38_i[i]) <<< 14;
            qual[i]   = (32'(r_sq38[i]) * 32'd3) <= 32'(Q_ONE * Q_ONE);
            flip[i]   = dg_sc[i] < $signed(32'(r_sq38[i]));
        end
        sel_min = 2'd0;
        if (r_sq38[1] < r_sq38[0]) begin
            sel_min = 2'd1;
        end
        if (r_sq38[2] < r_sq38[sel_min]) begin
            sel_min = 2'd2;
        end
        if (qual[0]) begin
            sel = 2'd0;
        end else if (qual[1]) begin
            sel = 2'd1;
        end else if (qual[2]) begin
            sel = 2'd2;
        end else begin
            sel = sel_min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_flip39 <= flip[sel];
            r_n39    <= {r_n38[2], r_n38[1], r_n38[0]};
        end
    end

    // Stage 23: squared cosine argument for the arcsine.
    logic [29:0] r_carg23;
    logic [29:0] ssq22;

    assign ssq22 = 30'(r_scl22) * 30'(r_scl22);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_carg23 <= 30'(Q_ONE * Q_ONE) - ssq22;
        end
    end

    // Stages 24 to 38: cosine; stages 39 to 53: arcsine by CORDIC.
    logic [14:0] c38;
    logic [14:0] s38;
    logic [14:0] z53;

    raae_isqrt #(.W(30)) u_cos_sqrt (
        .i_clk (i_clk),
        .i_en  (en),
        .i_v   (r_carg23),
        .o_r   (c38)
    );

    raae_dly #(.W(15), .D(16)) u_dly_s38 (
        .i_clk (i_clk), .i_en (en), .i_d (r_scl22), .o_d (s38)
    );

    raae_cordic u_cordic (
        .i_clk (i_clk),
        .i_en  (en),
        .i_c   (c38),
        .i_s   (s38),
        .o_z   (z53)
    );

    logic [48:0] nf53;
    logic [1:0]  pd53;

    raae_dly #(.W(49), .D(14)) u_dly_nf53 (
        .i_clk (i_clk), .i_en (en), .i_d ({r_flip39, r_n39}), .o_d (nf53)
    );

    raae_dly #(.W(2), .D(31)) u_dly_pd53 (
        .i_clk (i_clk), .i_en (en), .i_d ({r_deg22, r_prop22}), .o_d (pd53)
    );

    // Output register: the angle turns into pi minus itself for a negative cosine,
    // and non-proper or degenerate items carry zero data.
    logic [15:0] ang53;

    assign ang53 = nf53[48] ? (16'd32768 - 16'(z53)) : 16'(z53);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_odata <= '0;
            r_ouser <= '0;
        end else if (en) begin
            if (!pd53[0]) begin
                r_odata <= '0;
                r_ouser <= 2'b00;
            end else if (pd53[1]) begin
                r_odata <= '0;
                r_ouser <= 2'b11;
            end else begin
                r_odata <= {ang53, nf53[47:0]};
                r_ouser <= 2'b01;
            end
        end
    end

    assign o_m_axis_tvalid = r_ovld;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;

endmodule

### rtl/raae_chk.sv
// Port-level checker for the rotation axis and angle extractor, bound to the top level.
module raae_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic [143:0] i_s_axis_tdata,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [63:0]  o_m_axis_tdata,
    input logic [1:0]   o_m_axis_tuser,
    input logic         i_cfg_valid,
    input logic         o_cfg_ready,
    input logic [14:0]  i_cfg_data
);

    // A matrix that is not proper carries no other result.
    a_not_proper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |->
            o_m_axis_tdata == '0 && !o_m_axis_tuser[1])
        else $error("non-proper item with data or degenerate flag");

    // A degenerate rotation reports zero axis and angle.
    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1] |-> o_m_axis_tdata == '0)
        else $error("degenerate item with non-zero data");

    // A normal result has a unit-range axis and an angle of at most pi.
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == 2'b01 |->
            o_m_axis_tdata[63:48] <= 16'd32768
            && $signed(o_m_axis_tdata[15:0]) >= -16'sd16384
            && $signed(o_m_axis_tdata[15:0]) <= 16'sd16384
            && $signed(o_m_axis_tdata[31:16]) >= -16'sd16384
            && $signed(o_m_axis_tdata[31:16]) <= 16'sd16384
            && $signed(o_m_axis_tdata[47:32]) >= -16'sd16384
            && $signed(o_m_axis_tdata[47:32]) <= 16'sd16384)
        else $error("result out of range");

    // The input side stalls exactly when a waiting result is not taken.
    a_stall_coupling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("input ready does not follow the output stall");

    // A result that is not taken stays as it is.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output item changed while stalled");

endmodule

bind rotation_axis_angle_extract raae_chk u_raae_chk (.*);

### bench/raae_checker.sv
// Checker for the rotation extractor: predicts each result and compares it with the output.
module raae_checker
    import raae_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_valid,
    input  logic         i_s_ready,
    input  logic [143:0] i_s_data,
    input  logic         i_m_valid,
    input  logic         i_m_ready,
    input  logic [63:0]  i_m_data,
    input  logic [1:0]   i_m_user,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic [14:0]  i_cfg_data,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_matrices,
    output int           o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        proper;
        logic        degen;
        t_q14        ax;
        t_q14        ay;
        t_q14        az;
        logic [15:0] angle;
    } t_pose;

    localparam longint ARC_TAB [15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20,
                                         10, 5, 3, 1, 1};

    logic [14:0] sine_floor;
    t_pose       poses_due [$];

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint trunc_shift(longint v, int sh);
        return (v < 0) ? -((-v) >>> sh) : (v >>> sh);
    endfunction

    // Vectoring CORDIC from (cos, sin) back to the angle, in units of pi/32768.
    function automatic longint arcsine(longint s);
        longint x, y, z, dx, dy;
        z = 0;
        if (s < 0) s = 0;
        if (s > 16384) s = 16384;
        x = longint'(root_floor(longint'(268435456) - s * s)) * 256;
        y = s * 256;
        for (int i = 0; i < 15; i++) begin
            dx = trunc_shift(y, i);
            dy = trunc_shift(x, i);
            if (y > 0) begin
                x += dx; y -= dy; z += ARC_TAB[i];
            end else begin
                x -= dx; y += dy; z -= ARC_TAB[i];
            end
        end
        if (z < 0) z = 0;
        if (z > 16384) z = 16384;
        return z;
    endfunction

    function automatic t_pose extract_pose(logic [143:0] d);
        longint m [9];
        longint a [3];
        longint n [3];
        longint det, sine, ang, q;
        longint unsigned s2, r, mag;
        int sel;
        t_pose p;
        p = '{proper: 1'b0, degen: 1'b0, ax: '0, ay: '0, az: '0, angle: '0};
        for (int i = 0; i < 9; i++) m[i] = longint'($signed(d[16*i +: 16]));
        det = m[0] * (m[4] * m[8] - m[5] * m[7])
            - m[1] * (m[3] * m[8] - m[5] * m[6])
            + m[2] * (m[3] * m[7] - m[4] * m[6]);
        if (det < 0) return p;
        p.proper = 1'b1;
        a[0] = m[5] - m[7];
        a[1] = m[6] - m[2];
        a[2] = m[1] - m[3];
        s2   = longint'(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
        r    = root_floor(s2);
        sine = longint'(r >> 1);
        if (s2 == 0 || sine < longint'(sine_floor)) begin
            p.degen = 1'b1;
            return p;
        end
        for (int i = 0; i < 3; i++) begin
            mag  = (a[i] < 0) ? -a[i] : a[i];
            q    = longint'((mag * 16384 + (r >> 1)) / r);
            n[i] = (a[i] < 0) ? -q : q;
        end
        // Read the cosine sign from a component small enough to be well conditioned.
        sel = -1;
        for (int i = 0; i < 3; i++)
            if (sel < 0 && 3 * n[i] * n[i] <= 268435456) sel = i;
        if (sel < 0) begin
            sel = 0;
            for (int i = 1; i < 3; i++)
                if (n[i] * n[i] < n[sel] * n[sel]) sel = i;
        end
        ang = arcsine(sine);
        if (m[sel * 4] * 16384 < n[sel] * n[sel]) ang = 32768 - ang;
        p.ax    = t_q14'(n[0]);
        p.ay    = t_q14'(n[1]);
        p.az    = t_q14'(n[2]);
        p.angle = ang[15:0];
        return p;
    endfunction

    assign o_pending = poses_due.size();

    always @(posedge i_clk) begin
        t_pose want, got;
        if (!i_rst_n) begin
            sine_floor   <= 15'd16;
            o_fail_count <= 0;
            o_matrices   <= 0;
            o_results    <= 0;
            poses_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) sine_floor <= i_cfg_data;
            if (i_s_valid && i_s_ready) begin
                poses_due.push_back(extract_pose(i_s_data));
                o_matrices <= o_matrices + 1;
            end
            if (i_m_valid && i_m_ready) begin
                o_results <= o_results + 1;
                got.proper = i_m_user[0];
                got.degen  = i_m_user[1];
                got.ax     = i_m_data[15:0];
                got.ay     = i_m_data[31:16];
                got.az     = i_m_data[47:32];
                got.angle  = i_m_data[63:48];
                if (poses_due.size() == 0) begin
                    $display("%0t: unexpected result flags=%b data=%h", $time, i_m_user,
                             i_m_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = poses_due.pop_front();
                    if (got != want) begin
                        $display("%0t: mismatch expected proper=%b degen=%b axis=(%0d,%0d,%0d) angle=%0d",
                                 $time, want.proper, want.degen, want.ax, want.ay, want.az,
                                 want.angle);
                        $display("%0t:          actual   proper=%b degen=%b axis=(%0d,%0d,%0d) angle=%0d",
                                 $time, got.proper, got.degen, got.ax, got.ay, got.az,
                                 got.angle);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

### bench/testbench.sv
// Top of the rotation extractor bench: stimulus, configuration phases and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 70;     // a margin over the pipeline depth
    localparam int STALL_LIMIT   = 4000;   // cycles without any handshake
    localparam int PHASE_ITEMS   = 215;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [143:0] s_data = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [63:0]  m_data;
    logic [1:0]   m_user;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [14:0]  cfg_data = '0;

    int fail_count, pending, matrices, results;
    int sender_idle = 14;   // per cent of cycles in which no item is offered
    int sink_idle   = 60;   // per cent of cycles in which results are refused
    int quiet_cycles = 0;

    always #10 i_clk = ~i_clk;

    rotation_axis_angle_extract dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    raae_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_valid    (s_valid),
        .i_s_ready    (s_ready),
        .i_s_data     (s_data),
        .i_m_valid    (m_valid),
        .i_m_ready    (m_ready),
        .i_m_data     (m_data),
        .i_m_user     (m_user),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_matrices   (matrices),
        .o_results    (results)
    );

    // The result side refuses items at random, independently of the sender.
    always @(posedge i_clk) begin
        m_ready <= ($urandom_range(99) >= sink_idle);
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog expired at %0t", $time);
            $display("testbench failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [143:0] matrix(int a0, int a1, int a2, int a3, int a4, int a5,
                                            int a6, int a7, int a8);
        int v [9];
        logic [143:0] d;
        v = '{a0, a1, a2, a3, a4, a5, a6, a7, a8};
        for (int i = 0; i < 9; i++) d[16*i +: 16] = 16'(v[i]);
        return d;
    endfunction

    function automatic int to_q14(real v);
        int q;
        q = $rtoi(v * 16384.0 + ((v >= 0.0) ? 0.5 : -0.5));
        if (q > 16384) q = 16384;
        if (q < -16384) q = -16384;
        return q;
    endfunction

    // Rotation about axis (x, y, z) by theta radians, rounded to Q1.14.
    function automatic logic [143:0] rotation(real x, real y, real z, real theta);
        real len, c, s, t;
        len = $sqrt(x * x + y * y + z * z);
        if (len < 1.0e-6) begin
            x = 1.0; y = 0.0; z = 0.0; len = 1.0;
        end
        x = x / len; y = y / len; z = z / len;
        c = $cos(theta); s = $sin(theta); t = 1.0 - c;
        return matrix(to_q14(c + t * x * x),     to_q14(t * x * y - s * z), to_q14(t * x * z + s * y),
                      to_q14(t * x * y + s * z), to_q14(c + t * y * y),     to_q14(t * y * z - s * x),
                      to_q14(t * x * z - s * y), to_q14(t * y * z + s * x), to_q14(c + t * z * z));
    endfunction

    function automatic real unit_rand();
        return $urandom_range(20000) / 10000.0 - 1.0;
    endfunction

    task automatic send(logic [143:0] d);
        while ($urandom_range(99) < sender_idle) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        do @(posedge i_clk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The threshold is only changed with the pipeline empty.
    task automatic write_min_sine(logic [14:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Mostly clean rotations, with small angles near the threshold, near half-turns,
    // mirrored matrices, slightly perturbed ones and raw noise mixed in.
    task automatic send_random();
        int pick;
        real theta;
        logic [143:0] d;
        pick  = $urandom_range(99);
        theta = $urandom_range(32768) * 3.14159265358979 / 32768.0;
        if (pick < 15) theta = $urandom_range(600) / 16384.0;
        else if (pick < 25) theta = 3.14159265358979 - $urandom_range(600) / 16384.0;
        d = rotation(unit_rand(), unit_rand(), unit_rand(), theta);
        if (pick >= 80 && pick < 88) begin
            for (int i = 0; i < 9; i++)
                d[16*i +: 16] = -$signed(d[16*i +: 16]);
        end else if (pick >= 88 && pick < 93) begin
            for (int i = 0; i < 9; i++)
                d[16*i +: 16] = 16'($signed(d[16*i +: 16])
                                     + $signed(16'($urandom_range(64))) - 32);
        end else if (pick >= 93) begin
            for (int i = 0; i < 9; i++) d[16*i +: 16] = 16'($urandom);
        end
        send(d);
    endtask

    initial begin
        logic [14:0] thresholds [7];
        thresholds = '{15'd16, 15'd0, 15'd16384, 15'd32767, 15'd300,
                       15'($urandom_range(2000)), 15'd16};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed matrices under the reset threshold.
        send(matrix(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
        send(matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send(matrix(-16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
        send(matrix(16384, 0, 0, 0, 16384, 0, 0, 0, -16384));
        send(matrix(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
        send(matrix(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384));
        send(matrix(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384));
        send(matrix(16384, 0, 0, 0, 0, -16384, 0, 16384, 0));
        send(matrix(0, 0, 16384, 0, 16384, 0, -16384, 0, 0));
        send(matrix(0, -16384, 0, 16384, 0, 0, 0, 0, 16384));
        send(matrix(0, 0, 16384, 16384, 0, 0, 0, 16384, 0));
        send(matrix(16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384));
        send(matrix(-16384, -16384, -16384, -16384, -16384, -16384, -16384, -16384, -16384));
        send(matrix(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767));
        send(matrix(-32768, 32767, 0, -32767, -32768, 1, 0, -1, -32768));
        send(matrix(21845, -21846, 21845, -21846, 21845, -21846, 21845, -21846, 21845));
        send(rotation(1.0, 0.0, 0.0, 32.0 / 16384.0));
        send(rotation(0.0, 1.0, 0.0, 33.0 / 16384.0));
        send(rotation(0.3, -0.5, 0.8, 3.1355));
        send(rotation(-0.2, 0.9, 0.4, 1.0472));
        send(rotation(0.577, 0.577, 0.577, 2.0944));

        for (int ph = 0; ph < 7; ph++) begin
            if (ph == 2) begin
                sender_idle = 60; sink_idle = 14;
            end else if (ph == 4) begin
                sender_idle = 0; sink_idle = 0;
            end
            write_min_sine(thresholds[ph]);
            repeat (PHASE_ITEMS) send_random();
        end

        drain();
        $display("%0d matrices sent, %0d results checked, over seven threshold settings",
                 matrices, results);
        $display("including zero, full scale and all-ones thresholds and three idling patterns");
        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/raae_pkg.sv
rtl/raae_dly.sv
rtl/raae_isqrt.sv
rtl/raae_div.sv
rtl/raae_cordic.sv
rtl/rotation_axis_angle_extract.sv
rtl/raae_chk.sv
bench/raae_checker.sv
bench/testbench.sv
